### hdl/int_to_ascii_hex_dec_core_defines.svh
// Assertion macros shared by the int_to_ascii_hex_dec_core RTL.
// Expects signals named clock and reset in the scope that uses them.
`ifndef INT_TO_ASCII_HEX_DEC_CORE_DEFINES_SVH
`define INT_TO_ASCII_HEX_DEC_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ITHD_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ithd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ITHD_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ithd: next-cycle check failed");

`endif

### hdl/ithd_pkg.sv
// Package for int_to_ascii_hex_dec_core: payload types, job type, FSM states,
// fixed sizes and the digit-to-character mapping. No dependencies.
`timescale 1ns / 1ps

package ithd_pkg;

   localparam int VALUE_W     = 64;
   localparam int CHAR_W      = 7;
   localparam int CNT_W       = 5;
   localparam int NIB_W       = 4;
   localparam int NUM_DIGITS  = 20;
   localparam int HEX_DIGITS  = VALUE_W / NIB_W;
   localparam int DIG_BITS    = NUM_DIGITS * NIB_W;
   localparam int DABBLE_BPC  = 4;
   localparam int DABBLE_CYC  = VALUE_W / DABBLE_BPC;
   localparam int STEP_W      = $clog2(DABBLE_CYC);

   localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_LOW_A = 7'h61;
   localparam logic [CHAR_W-1:0] ASCII_UP_A  = 7'h41;

   typedef enum logic [1:0] {
      CMD_HEX_LOWER = 2'd0,
      CMD_HEX_UPPER = 2'd1,
      CMD_DEC       = 2'd2,
      CMD_NONE      = 2'd3
   } cmd_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [1:0]                cmd;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic [CNT_W-1:0]  chars_so_far;
      logic              is_last;
   } rsp_type;

   // Classified work handed from the front end to the converter.
   typedef struct packed {
      logic               neg;
      logic               upper;
      logic               dec;
      logic [VALUE_W-1:0] mag;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } back_state_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] nib,
                                                    input logic upper);
      logic [CHAR_W-1:0] nib_ext;
      nib_ext = {{(CHAR_W-NIB_W){1'b0}}, nib};
      if (nib < 4'd10) begin
         digit_char = ASCII_ZERO + nib_ext;
      end else if (upper) begin
         digit_char = ASCII_UP_A + nib_ext - 7'd10;
      end else begin
         digit_char = ASCII_LOW_A + nib_ext - 7'd10;
      end
   endfunction

endpackage

### hdl/ithd_front.sv
// Front end: takes request transfers, forms sign and magnitude, decodes the mode.
// Depends on ithd_pkg.
`timescale 1ns / 1ps

module ithd_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  ithd_pkg::req_type req_data,
   output logic             push_valid,
   input  logic             push_ready,
   output ithd_pkg::job_type push_job
);
   import ithd_pkg::*;

   logic neg;
   logic keep;

   // Drop unknown modes: accept the transfer but queue nothing.
   always_comb begin
      neg               = req_data.value[VALUE_W-1];
      push_job.neg      = neg;
      push_job.mag      = neg ? (VALUE_W'(0) - VALUE_W'(req_data.value))
                              : VALUE_W'(req_data.value);
      push_job.upper    = 1'b0;
      push_job.dec      = 1'b0;
      keep              = 1'b1;
      case (cmd_type'(req_data.cmd))
         CMD_HEX_LOWER: begin
            push_job.upper = 1'b0;
         end
         CMD_HEX_UPPER: begin
            push_job.upper = 1'b1;
         end
         CMD_DEC: begin
            push_job.dec = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid && keep;

endmodule

### hdl/ithd_queue.sv
// Small job queue between front end and converter so each side stalls alone.
// Depends on ithd_pkg.
`timescale 1ns / 1ps

module ithd_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ithd_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ithd_pkg::job_type pop_job
);
   import ithd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QCNT_W = $clog2(DEPTH + 1);

   job_type           entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### hdl/ithd_back.sv
// Converter: turns a queued job into digits (shift-add-3 for decimal) and
// emits one character per response transfer. Depends on ithd_pkg and the defines.
`timescale 1ns / 1ps
`include "int_to_ascii_hex_dec_core_defines.svh"

module ithd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_pop,
   input  ithd_pkg::job_type job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ithd_pkg::rsp_type rsp_data
);
   import ithd_pkg::*;

   back_state_type        state_ff, state_in;
   logic [DIG_BITS-1:0]   dig_ff;
   logic [VALUE_W-1:0]    bin_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [CNT_W-1:0]      left_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  neg_ff;
   logic                  upper_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [DIG_BITS-1:0]   conv_bcd;
   logic [VALUE_W-1:0]    conv_bin;
   logic [NIB_W-1:0]      top_nib;
   logic                  out_load;
   logic                  step_last;
   logic                  skip_more;
   logic                  skip_shift;
   logic                  emit_char;
   logic                  emit_shift;

   assign top_nib   = dig_ff[DIG_BITS-1 -: NIB_W];
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign step_last = (step_ff == STEP_W'(DABBLE_CYC - 1));
   assign skip_more = (top_nib == '0) && (left_ff > CNT_W'(1));

   // Several shift-add-3 steps per cycle; each digit adjusts independently.
   always_comb begin
      conv_bcd = dig_ff;
      conv_bin = bin_ff;
      for (int s = 0; s < DABBLE_BPC; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (conv_bcd[d*NIB_W +: NIB_W] >= 4'd5) begin
               conv_bcd[d*NIB_W +: NIB_W] = conv_bcd[d*NIB_W +: NIB_W] + 4'd3;
            end
         end
         {conv_bcd, conv_bin} = {conv_bcd[DIG_BITS-2:0], conv_bin, 1'b0};
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = job.dec ? ST_CONV : ST_SKIP;
            end
         end
         ST_CONV: begin
            if (step_last) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!skip_more) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_load) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load && (left_ff == CNT_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      job_pop    = 1'b0;
      skip_shift = 1'b0;
      emit_char  = 1'b0;
      emit_shift = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            job_pop = job_valid;
         end
         ST_SKIP: begin
            skip_shift = skip_more;
         end
         ST_SIGN: begin
            emit_char = out_load;
         end
         ST_EMIT: begin
            emit_char  = out_load;
            emit_shift = out_load;
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_data_in.char_code    = (state_ff == ST_SIGN) ? ASCII_MINUS
                                                      : digit_char(top_nib, upper_ff);
      rsp_data_in.chars_so_far = cnt_ff + 1'b1;
      rsp_data_in.is_last      = (state_ff == ST_EMIT) && (left_ff == CNT_W'(1));
      if (emit_char) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (job_pop) begin
            cnt_ff  <= '0;
            left_ff <= job.dec ? CNT_W'(NUM_DIGITS) : CNT_W'(HEX_DIGITS);
         end else begin
            if (emit_char) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (skip_shift || emit_shift) begin
               left_ff <= left_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         neg_ff   <= job.neg;
         upper_ff <= job.upper;
         step_ff  <= '0;
         bin_ff   <= job.mag;
         if (job.dec) begin
            dig_ff <= '0;
         end else begin
            dig_ff <= {job.mag, {(DIG_BITS-VALUE_W){1'b0}}};
         end
      end else if (state_ff == ST_CONV) begin
         dig_ff  <= conv_bcd;
         bin_ff  <= conv_bin;
         step_ff <= step_ff + 1'b1;
      end else if (skip_shift || emit_shift) begin
         dig_ff <= {dig_ff[DIG_BITS-NIB_W-1:0], {NIB_W{1'b0}}};
      end
      if (emit_char) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ITHD_ASSERT_IMP(a_emit_has_digit, state_ff == ST_EMIT, left_ff != '0)
   `ITHD_ASSERT_IMP(a_sign_only_neg, state_ff == ST_SIGN, neg_ff)
   `ITHD_ASSERT_NXT(a_conv_ends, (state_ff == ST_CONV) && step_last, state_ff == ST_SKIP)
   `ITHD_ASSERT_NXT(a_last_to_idle, emit_char && rsp_data_in.is_last,
                    (state_ff == ST_IDLE) && rsp_valid_ff && rsp_data_ff.is_last)

endmodule

### hdl/int_to_ascii_hex_dec_core.sv
// Top level of the integer to ASCII converter: front end, job queue, converter.
// Depends on ithd_pkg, ithd_front, ithd_queue and ithd_back.
`timescale 1ns / 1ps
//
// Usage
//   Request channel (req_valid/req_ready/req_data): one transfer carries a signed
//   64-bit value and a mode (lower-case hex, upper-case hex, decimal). A transfer
//   with the unknown mode is taken and dropped; it yields no characters.
//   Response channel (rsp_valid/rsp_ready/rsp_data): one transfer per character,
//   most significant first, with a leading '-' for negative values. Each carries
//   the running character count and a last flag on the final character.
//   After the request transfer the job passes through the queue; the converter pops
//   it, runs a decimal job through the shift-add-3 unit (four bits per cycle), skips
//   leading zero digits, then emits the sign if negative and the digits. Characters
//   leave at one per cycle while the receiver is ready. The single converter works
//   on one number at a time and pops the next job only after the last character of
//   the previous one has been emitted.
//   The job queue (QUEUE_DEPTH entries) lets requests be taken while the
//   converter is busy. When the receiver stalls, the output register holds the
//   character and the converter waits; the queue fills and req_ready then drops.
//   Reset (synchronous, active high) empties the queue and the output register.
//
module int_to_ascii_hex_dec_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ithd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ithd_pkg::rsp_type rsp_data
);
   import ithd_pkg::*;

   // Front end to queue
   logic    push_valid;
   logic    push_ready;
   job_type push_job;

   // Queue to converter
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   // Classify each request transfer; drop unknown modes here.
   ithd_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   // Hold classified jobs while the converter works through earlier ones.
   ithd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Convert and emit characters through the output register.
   ithd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_pop   (pop_ready),
      .job       (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/tb.sv
// Self-checking testbench for int_to_ascii_hex_dec_core: converts signed 64-bit numbers to
// ASCII text and checks each character against a built-in predictor.
// Depends on ithd_pkg and the int_to_ascii_hex_dec_core RTL.
`timescale 1ns / 1ps

module tb;
   import ithd_pkg::*;

   // Watchdog: cycles with no transfer on either channel before the run is abandoned.
   // The long receiver hold-off (HOLD_CYCLES) plus a decimal conversion stays well below it.
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 300;
   // Settling time at the end, after every owed character has arrived.
   localparam int DRAIN_CYCLES = 60;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Characters still owed by the block, oldest first.
   rsp_type exp_chars[$];
   int      errors       = 0;
   int      quiet_cycles = 0;
   bit      idle_on      = 1'b0;
   bit      hold_rsp     = 1'b0;

   int_to_ascii_hex_dec_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Work out the text of one number and queue its characters.
   // Sign first, then the magnitude's digits, most significant first.
   function automatic void predict_text(input req_type item);
      logic              neg;
      logic              upper;
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] radix;
      logic [NIB_W-1:0]  dgt;
      logic [CHAR_W-1:0] rev[NUM_DIGITS];
      logic [CHAR_W-1:0] text[NUM_DIGITS];
      int                nd;
      int                n;
      int                k;
      rsp_type           c;
      nd = 0;
      n  = 0;
      case (cmd_type'(item.cmd))
         CMD_HEX_LOWER: begin
            radix = VALUE_W'(16);
            upper = 1'b0;
         end
         CMD_HEX_UPPER: begin
            radix = VALUE_W'(16);
            upper = 1'b1;
         end
         CMD_DEC: begin
            radix = VALUE_W'(10);
            upper = 1'b0;
         end
         default: begin
            // Unknown mode: the transfer is dropped without output.
            return;
         end
      endcase
      neg = item.value[VALUE_W-1];
      // Unsigned negate, so the most negative value keeps its full magnitude.
      mag = neg ? {VALUE_W{1'b0}} - item.value : item.value;
      do begin
         dgt = NIB_W'(mag % radix);
         if (dgt < 4'd10) begin
            rev[nd] = ASCII_ZERO + CHAR_W'(dgt);
         end else if (upper) begin
            rev[nd] = ASCII_UP_A + CHAR_W'(dgt) - 7'd10;
         end else begin
            rev[nd] = ASCII_LOW_A + CHAR_W'(dgt) - 7'd10;
         end
         nd++;
         mag = mag / radix;
      end while (mag != 0 && nd < NUM_DIGITS - 1);
      if (neg) begin
         text[n] = ASCII_MINUS;
         n++;
      end
      for (k = nd - 1; k >= 0; k--) begin
         text[n] = rev[k];
         n++;
      end
      for (k = 0; k < n; k++) begin
         c.char_code    = text[k];
         c.chars_so_far = CNT_W'(k + 1);
         c.is_last      = (k == n - 1);
         exp_chars.push_back(c);
      end
   endfunction

   task automatic report_mismatch(input string field, input int want, input int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
   endtask

   // Sample both channels at each rising edge (pre-edge values): predict on a request
   // transfer, compare on a character transfer, and run the watchdog.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_text(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (exp_chars.size() == 0) begin
               $display("%0t: unexpected character, expected none, actual %h", $time,
                        rsp_data);
               errors++;
            end else begin
               want = exp_chars.pop_front();
               if (rsp_data.char_code !== want.char_code) begin
                  report_mismatch("char_code", int'(want.char_code),
                                  int'(rsp_data.char_code));
               end
               if (rsp_data.chars_so_far !== want.chars_so_far) begin
                  report_mismatch("chars_so_far", int'(want.chars_so_far),
                                  int'(rsp_data.chars_so_far));
               end
               if (rsp_data.is_last !== want.is_last) begin
                  report_mismatch("is_last", int'(want.is_last), int'(rsp_data.is_last));
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d characters outstanding", $time,
                     IDLE_LIMIT, exp_chars.size());
            $display("int_to_ascii_hex_dec_core test failed");
            $finish;
         end
      end
   end

   // Receiver: ready most of the time, random stall bursts while idling is on,
   // and one long hold-off on request so that the queue fills and req_ready drops.
   initial begin
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one number and hold it until the transfer. Called just after a rising edge;
   // returns just after the edge that took it, so valid stays high into the next call.
   task automatic send_number(input logic signed [VALUE_W-1:0] num, input cmd_type mode);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= '{value: num, cmd: mode};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Mix of full-width, shortened, tiny and negative values so that every digit count
   // and both signs turn up.
   function automatic logic [VALUE_W-1:0] rand_value();
      logic [VALUE_W-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: v = v >> $urandom_range(1, 63);
         1: v = VALUE_W'($urandom_range(0, 300));
         2: v = {VALUE_W{1'b0}} - (v >> $urandom_range(1, 63));
         3: v = {VALUE_W{1'b0}} - VALUE_W'($urandom_range(0, 300));
         default: ;
      endcase
      return v;
   endfunction

   // Send numbers until 'count' of them carry a real mode; dropped transfers are extra.
   task automatic send_random(input int count);
      int      sent;
      cmd_type mode;
      sent = 0;
      while (sent < count) begin
         mode = ($urandom_range(0, 9) == 0) ? CMD_NONE : cmd_type'($urandom_range(0, 2));
         send_number(rand_value(), mode);
         if (mode != CMD_NONE) begin
            sent++;
         end
      end
   endtask

   // Drop valid and wait for every owed character; always advances at least one edge.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (exp_chars.size() != 0);
   endtask

   // Zero, extremes, every mode, all hex letters in both cases, the most negative value
   // (the twenty-character decimal case) and the unknown mode.
   task automatic test_directed();
      idle_on = 1'b0;
      send_number(64'sd0, CMD_HEX_LOWER);
      send_number(64'sd0, CMD_HEX_UPPER);
      send_number(64'sd0, CMD_DEC);
      send_number(64'sh8000_0000_0000_0000, CMD_HEX_LOWER);
      send_number(64'sh8000_0000_0000_0000, CMD_HEX_UPPER);
      send_number(64'sh8000_0000_0000_0000, CMD_DEC);
      send_number(64'sh7fff_ffff_ffff_ffff, CMD_HEX_LOWER);
      send_number(64'sh7fff_ffff_ffff_ffff, CMD_HEX_UPPER);
      send_number(64'sh7fff_ffff_ffff_ffff, CMD_DEC);
      send_number(-64'sd1, CMD_HEX_LOWER);
      send_number(-64'sd1, CMD_DEC);
      send_number(64'sh0123_4567_89ab_cdef, CMD_HEX_LOWER);
      send_number(64'sh0123_4567_89ab_cdef, CMD_HEX_UPPER);
      send_number(64'shfedc_ba98_7654_3210, CMD_HEX_UPPER);
      send_number(64'sd1000000000000000000, CMD_DEC);
      send_number(64'sd9, CMD_DEC);
      send_number(-64'sd10, CMD_DEC);
      send_number(64'sd15, CMD_HEX_LOWER);
      send_number(64'sd15, CMD_HEX_UPPER);
      send_number(64'sh8000_0000_0000_0000, CMD_NONE);
      send_number(64'sh7fff_ffff_ffff_ffff, CMD_NONE);
      send_number(64'sd123, CMD_DEC);
   endtask

   task automatic test_random_idle();
      idle_on = 1'b1;
      send_random(150);
   endtask

   // Hold the receiver off while offering numbers: the queue fills and input stalls.
   task automatic test_receiver_hold();
      hold_rsp = 1'b1;
      send_random(25);
   endtask

   // Let everything drain with the sender quiet, then carry on.
   task automatic test_sender_pause();
      wait_for_drain();
      send_random(35);
   endtask

   // Last stretch: no idling on either side, back-to-back transfers.
   task automatic test_steady();
      idle_on = 1'b0;
      send_random(90);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_idle();
      test_receiver_hold();
      test_sender_pause();
      test_steady();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && exp_chars.size() == 0) begin
         $display("int_to_ascii_hex_dec_core test passed");
      end else begin
         $display("int_to_ascii_hex_dec_core test failed");
      end
      $finish;
   end

endmodule
